// ----- src/tec_pkg.sv -----
package tec_pkg;

    localparam int COORD_BITS = 16;
    localparam int SQ_W = 2 * COORD_BITS + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int SQRT_STAGES = ROOT_W;

    localparam int DIV_W = 64;
    localparam int DVS_W = 32;
    localparam int DIV_STAGES = DIV_W;

    localparam int COST_W = 64;
    localparam logic [COST_W-1:0] COST_MAX = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam int ADDR_W = 3;
    localparam logic REG_TIME_SENSITIVE = 1'b0;
    localparam logic REG_SAT_PERCENT = 1'b1;
    localparam logic [7:0] SAT_PERCENT_RESET = 8'd100;

    localparam logic [1:0] KIND_RIDE = 2'd0;
    localparam logic [1:0] KIND_BOARD = 2'd1;
    localparam logic [1:0] KIND_ALIGHT = 2'd2;

endpackage

// ----- src/tec_sqrt.sv -----
module tec_sqrt
    import tec_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root,
    output logic              rem_nz
);

    localparam int REM_W = ROOT_W + 4;

    logic [SQ_W-1:0]   s_reg     [SQRT_STAGES];
    logic [SQ_W-1:0]   s_next    [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg   [SQRT_STAGES];
    logic [REM_W-1:0]  rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_next [SQRT_STAGES];

    logic [SQ_W-1:0]   src_s     [SQRT_STAGES];
    logic [REM_W-1:0]  src_rem   [SQRT_STAGES];
    logic [ROOT_W-1:0] src_root  [SQRT_STAGES];
    logic [REM_W-1:0]  part      [SQRT_STAGES];
    logic [REM_W-1:0]  trial     [SQRT_STAGES];

    always_comb
    begin
        src_s[0] = radicand;
        src_rem[0] = '0;
        src_root[0] = '0;
        for (int i = 1; i < SQRT_STAGES; i++)
        begin
            src_s[i] = s_reg[i-1];
            src_rem[i] = rem_reg[i-1];
            src_root[i] = root_reg[i-1];
        end
        // one root bit per stage, two radicand bits shifted in
        for (int i = 0; i < SQRT_STAGES; i++)
        begin
            part[i] = {src_rem[i][REM_W-3:0], src_s[i][SQ_W-1 -: 2]};
            trial[i] = REM_W'({src_root[i], 2'b01});
            s_next[i] = src_s[i] << 2;
            if (part[i] >= trial[i])
            begin
                rem_next[i] = part[i] - trial[i];
                root_next[i] = {src_root[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = part[i];
                root_next[i] = {src_root[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_STAGES; i++)
            begin
                s_reg[i] <= s_next[i];
                rem_reg[i] <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];
    assign rem_nz = |rem_reg[SQRT_STAGES-1];

endmodule

// ----- src/tec_div.sv -----
module tec_div
    import tec_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    logic [DIV_W-1:0] nq_reg   [DIV_STAGES];
    logic [DIV_W-1:0] nq_next  [DIV_STAGES];
    logic [DVS_W-1:0] rem_reg  [DIV_STAGES];
    logic [DVS_W-1:0] rem_next [DIV_STAGES];
    logic [DVS_W-1:0] dvs_reg  [DIV_STAGES];
    logic [DVS_W-1:0] dvs_next [DIV_STAGES];

    logic [DIV_W-1:0] src_nq   [DIV_STAGES];
    logic [DVS_W-1:0] src_rem  [DIV_STAGES];
    logic [DVS_W-1:0] src_dvs  [DIV_STAGES];
    logic [DVS_W:0]   part     [DIV_STAGES];
    logic             ge       [DIV_STAGES];

    always_comb
    begin
        src_nq[0] = dividend;
        src_rem[0] = '0;
        src_dvs[0] = divisor;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            src_nq[i] = nq_reg[i-1];
            src_rem[i] = rem_reg[i-1];
            src_dvs[i] = dvs_reg[i-1];
        end
        // dividend bits leave at the top, quotient bits enter at the bottom
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            part[i] = {src_rem[i], src_nq[i][DIV_W-1]};
            ge[i] = part[i] >= {1'b0, src_dvs[i]};
            if (ge[i])
                rem_next[i] = DVS_W'(part[i] - {1'b0, src_dvs[i]});
            else
                rem_next[i] = part[i][DVS_W-1:0];
            nq_next[i] = {src_nq[i][DIV_W-2:0], ge[i]};
            dvs_next[i] = src_dvs[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                nq_reg[i] <= nq_next[i];
                rem_reg[i] <= rem_next[i];
                dvs_reg[i] <= dvs_next[i];
            end
        end
    end

    assign quotient = nq_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1] | (dvs_reg[DIV_STAGES-1] & '0);

endmodule

// ----- src/transit_edge_cost.sv -----
// Edge cost unit for a transit routing graph. One edge word is taken per clock while the
// output is taken; the pipeline has no internal back pressure, so a steady stream of one
// edge per cycle is sustained. It holds two 64-stage restoring dividers (flow or paired
// flow over threshold or capacity, then the fractional penalty), one quotient bit per
// stage, and the 17-stage square root for the distance. When a finished cost is not
// taken, the whole pipeline holds and in_ready drops. Both registers may be written at any
// time the unit is empty; time_sensitive is at 0x0 and saturation_percent at 0x4.
module transit_edge_cost
    import tec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            edge_kind,
    input  logic [31:0]           travel_time,
    input  logic [31:0]           capacity,
    input  logic [31:0]           headway,
    input  logic [63:0]           flow,
    input  logic [63:0]           paired_flow,
    input  logic                  timed,
    input  logic signed [15:0]    from_x,
    input  logic signed [15:0]    from_y,
    input  logic signed [15:0]    to_x,
    input  logic signed [15:0]    to_y,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COST_W-1:0]     cost
);

    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int DIV100_SHIFT = 37;
    localparam int Q100_W = 26;
    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam int BP_W = 14;
    localparam int SMALL_MUL_W = 27;
    localparam logic [12:0] SMALL_MAGIC = 13'd5243;
    localparam int SMALL_SHIFT = 19;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] travel;
        logic [31:0] cap;
        logic [31:0] headway;
        logic [63:0] flow;
        logic [63:0] paired;
        logic        timed;
        logic        ts;
        logic [6:0]  pct;
    } item_t;

    typedef struct packed {
        item_t              it;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } a_t;

    typedef struct packed {
        item_t                 it;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [63:0]           cm;
    } b_t;

    typedef struct packed {
        item_t             it;
        logic [SQ_W-1:0]   sq;
        logic [Q100_W-1:0] q100;
    } c_t;

    typedef struct packed {
        item_t           it;
        logic [SQ_W-1:0] sq;
        logic [6:0]      b100;
        logic [32:0]     apct;
    } d_t;

    typedef struct packed {
        item_t           it;
        logic [SQ_W-1:0] sq;
        logic [BP_W-1:0] bp;
        logic [32:0]     apct;
    } e_t;

    typedef struct packed {
        item_t           it;
        logic [SQ_W-1:0] sq;
        logic [6:0]      small_part;
        logic [32:0]     apct;
    } f_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      travel;
        logic [31:0]      headway;
        logic             ts;
        logic             timed;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } s_side_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      travel;
        logic [31:0]      headway;
        logic             ts;
        logic             timed;
        logic [31:0]      base;
        logic [DVS_W-1:0] divisor;
    } d1_side_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      travel;
        logic [31:0]      base;
        logic             ts;
        logic             timed;
        logic [DVS_W-1:0] divisor;
        logic [64:0]      p_lo;
        logic [64:0]      p_hi;
        logic [63:0]      fr;
    } i_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       travel;
        logic [31:0]       base;
        logic              ts;
        logic              timed;
        logic [COST_W-1:0] whole;
    } d2_side_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       base;
        logic              ts;
        logic              timed;
        logic [COST_W-1:0] sum;
    } k_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] x,
                                                  input logic [COST_W-1:0] y);
        logic [COST_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
    endfunction

    // configuration
    logic       ts_reg;
    logic [7:0] pct_reg;
    logic       cfg_wr;
    logic       cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= 1'b0;
            pct_reg <= SAT_PERCENT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TIME_SENSITIVE: ts_reg <= pwdata[0];
                REG_SAT_PERCENT:    pct_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TIME_SENSITIVE: prdata = {31'b0, ts_reg};
            REG_SAT_PERCENT:    prdata = {24'b0, pct_reg};
            default:            prdata = '0;
        endcase
    end

    // pipeline control: everything advances together
    logic en;
    logic l_v_reg;
    assign en = !l_v_reg || out_ready;
    assign in_ready = en;

    a_t a_reg, a_next;
    b_t b_reg, b_next;
    c_t c_reg, c_next;
    d_t d_reg, d_next;
    e_t e_reg, e_next;
    f_t f_reg, f_next;
    s_side_t g_reg, g_next;
    logic [SQ_W-1:0] g_sq_reg, g_sq_next;
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;

    s_side_t sq_side_reg [SQRT_STAGES];
    logic    sq_v_reg    [SQRT_STAGES];

    d1_side_t h_reg, h_next;
    logic [DIV_W-1:0] h_dividend_reg, h_dividend_next;
    logic h_v_reg;

    d1_side_t d1_side_reg [DIV_STAGES];
    logic     d1_v_reg    [DIV_STAGES];

    i_t i_reg, i_next;
    logic i_v_reg;

    d2_side_t j_reg, j_next;
    logic [63:0] j_fr_reg, j_fr_next;
    logic [DVS_W-1:0] j_dvs_reg, j_dvs_next;
    logic j_v_reg;

    d2_side_t d2_side_reg [DIV_STAGES];
    logic     d2_v_reg    [DIV_STAGES];

    k_t k_reg, k_next;
    logic k_v_reg;

    logic [COST_W-1:0] cost_reg, cost_next;

    logic [ROOT_W-1:0] sq_root;
    logic              sq_rem_nz;
    logic [DIV_W-1:0]  q1, q2;
    logic [DVS_W-1:0]  r1, r2;

    logic signed [COORD_BITS:0] diff_x, diff_y;
    logic [31:0] thr, capdiv;
    logic [32:0] scale, mop;
    logic [96:0] full;

    always_comb
    begin
        a_next.it.kind = edge_kind;
        a_next.it.travel = travel_time;
        a_next.it.cap = capacity;
        a_next.it.headway = headway;
        a_next.it.flow = flow;
        a_next.it.paired = paired_flow;
        a_next.it.timed = timed;
        a_next.it.ts = ts_reg;
        a_next.it.pct = (pct_reg > 8'(PCT_MAX)) ? PCT_MAX : pct_reg[6:0];
        a_next.fx = from_x;
        a_next.fy = from_y;
        a_next.tx = to_x;
        a_next.ty = to_y;

        diff_x = $signed({a_reg.fx[COORD_BITS-1], a_reg.fx[COORD_BITS-1:0]})
               - $signed({a_reg.tx[COORD_BITS-1], a_reg.tx[COORD_BITS-1:0]});
        diff_y = $signed({a_reg.fy[COORD_BITS-1], a_reg.fy[COORD_BITS-1:0]})
               - $signed({a_reg.ty[COORD_BITS-1], a_reg.ty[COORD_BITS-1:0]});
        b_next.it = a_reg.it;
        b_next.dx = COORD_BITS'(diff_x[COORD_BITS] ? -diff_x : diff_x);
        b_next.dy = COORD_BITS'(diff_y[COORD_BITS] ? -diff_y : diff_y);
        // capacity / 100 by reciprocal, exact over 32 bits
        b_next.cm = {32'b0, a_reg.it.cap} * {32'b0, DIV100_MAGIC};

        c_next.it = b_reg.it;
        c_next.sq = SQ_W'(b_reg.dx) * SQ_W'(b_reg.dx) + SQ_W'(b_reg.dy) * SQ_W'(b_reg.dy);
        c_next.q100 = b_reg.cm[DIV100_SHIFT +: Q100_W];

        // cap*pct/100 = (cap/100)*pct + (cap%100)*pct/100
        d_next.it = c_reg.it;
        d_next.sq = c_reg.sq;
        d_next.b100 = 7'(c_reg.it.cap - 32'(c_reg.q100) * 32'(PCT_MAX));
        d_next.apct = 33'(c_reg.q100) * 33'(c_reg.it.pct);

        e_next.it = d_reg.it;
        e_next.sq = d_reg.sq;
        e_next.bp = BP_W'(d_reg.b100) * BP_W'(d_reg.it.pct);
        e_next.apct = d_reg.apct;

        f_next.it = e_reg.it;
        f_next.sq = e_reg.sq;
        f_next.small_part = 7'((SMALL_MUL_W'(e_reg.bp) * SMALL_MUL_W'(SMALL_MAGIC))
                               >> SMALL_SHIFT);
        f_next.apct = e_reg.apct;

        thr = f_reg.apct[31:0] + 32'(f_reg.small_part);
        if (thr == '0)
            thr = 32'd1;
        capdiv = (f_reg.it.cap == '0) ? 32'd1 : f_reg.it.cap;
        g_next.kind = f_reg.it.kind;
        g_next.travel = f_reg.it.travel;
        g_next.headway = f_reg.it.headway;
        g_next.ts = f_reg.it.ts;
        g_next.timed = f_reg.it.timed;
        if (f_reg.it.kind == KIND_BOARD)
        begin
            g_next.dividend = f_reg.it.paired;
            g_next.divisor = capdiv;
        end
        else
        begin
            g_next.dividend = f_reg.it.flow;
            g_next.divisor = thr;
        end
        g_sq_next = f_reg.sq;

        h_next.kind = sq_side_reg[SQRT_STAGES-1].kind;
        h_next.travel = sq_side_reg[SQRT_STAGES-1].travel;
        h_next.headway = sq_side_reg[SQRT_STAGES-1].headway;
        h_next.ts = sq_side_reg[SQRT_STAGES-1].ts;
        h_next.timed = sq_side_reg[SQRT_STAGES-1].timed;
        h_next.divisor = sq_side_reg[SQRT_STAGES-1].divisor;
        if (sq_side_reg[SQRT_STAGES-1].ts && sq_side_reg[SQRT_STAGES-1].travel != '0)
            h_next.base = sq_side_reg[SQRT_STAGES-1].travel;
        else
            h_next.base = 32'(sq_root) + 32'(sq_rem_nz);
        h_dividend_next = sq_side_reg[SQRT_STAGES-1].dividend;

        scale = 33'(d1_side_reg[DIV_STAGES-1].base) + 33'd1;
        mop = (d1_side_reg[DIV_STAGES-1].kind == KIND_BOARD)
            ? 33'(d1_side_reg[DIV_STAGES-1].headway) : scale;
        i_next.kind = d1_side_reg[DIV_STAGES-1].kind;
        i_next.travel = d1_side_reg[DIV_STAGES-1].travel;
        i_next.base = d1_side_reg[DIV_STAGES-1].base;
        i_next.ts = d1_side_reg[DIV_STAGES-1].ts;
        i_next.timed = d1_side_reg[DIV_STAGES-1].timed;
        i_next.divisor = d1_side_reg[DIV_STAGES-1].divisor;
        i_next.p_lo = 65'(mop) * 65'(q1[31:0]);
        i_next.p_hi = 65'(mop) * 65'(q1[63:32]);
        // remainder < divisor (threshold or capacity), so this product stays below 2^64
        i_next.fr = 64'(65'(scale) * 65'(r1));

        full = {i_reg.p_hi, 32'b0} + 97'(i_reg.p_lo);
        j_next.kind = i_reg.kind;
        j_next.travel = i_reg.travel;
        j_next.base = i_reg.base;
        j_next.ts = i_reg.ts;
        j_next.timed = i_reg.timed;
        j_next.whole = (full > 97'(COST_MAX)) ? COST_MAX : full[COST_W-1:0];
        j_fr_next = i_reg.fr;
        j_dvs_next = i_reg.divisor;

        k_next.kind = d2_side_reg[DIV_STAGES-1].kind;
        k_next.base = d2_side_reg[DIV_STAGES-1].base;
        k_next.ts = d2_side_reg[DIV_STAGES-1].ts;
        k_next.timed = d2_side_reg[DIV_STAGES-1].timed;
        if (d2_side_reg[DIV_STAGES-1].kind == KIND_BOARD)
            k_next.sum = sat_add(64'(d2_side_reg[DIV_STAGES-1].travel),
                                 d2_side_reg[DIV_STAGES-1].whole);
        else
            k_next.sum = sat_add(d2_side_reg[DIV_STAGES-1].whole, q2);

        case (k_reg.kind)
            KIND_RIDE:
            begin
                if (k_reg.ts && k_reg.timed)
                    cost_next = 64'(k_reg.base);
                else
                    cost_next = sat_add(64'(k_reg.base), k_reg.sum);
            end
            KIND_BOARD:  cost_next = k_reg.ts ? k_reg.sum : '0;
            KIND_ALIGHT: cost_next = '0;
            default:     cost_next = '0;
        endcase
    end

    tec_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (g_sq_reg),
        .root     (sq_root),
        .rem_nz   (sq_rem_nz)
    );

    tec_div u_div_flow (
        .clk       (clk),
        .en        (en),
        .dividend  (h_dividend_reg),
        .divisor   (h_reg.divisor),
        .quotient  (q1),
        .remainder (r1)
    );

    tec_div u_div_frac (
        .clk       (clk),
        .en        (en),
        .dividend  (j_fr_reg),
        .divisor   (j_dvs_reg),
        .quotient  (q2),
        .remainder (r2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            f_reg <= f_next;
            g_reg <= g_next;
            g_sq_reg <= g_sq_next;
            sq_side_reg[0] <= g_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
            h_reg <= h_next;
            h_dividend_reg <= h_dividend_next;
            d1_side_reg[0] <= h_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                d1_side_reg[i] <= d1_side_reg[i-1];
            i_reg <= i_next;
            j_reg <= j_next;
            j_fr_reg <= j_fr_next;
            j_dvs_reg <= j_dvs_next;
            d2_side_reg[0] <= j_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                d2_side_reg[i] <= d2_side_reg[i-1];
            k_reg <= k_next;
            // final remainder carries no information for the cost
            cost_reg <= cost_next | (64'(r2) & '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            for (int i = 0; i < SQRT_STAGES; i++)
                sq_v_reg[i] <= 1'b0;
            h_v_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                d1_v_reg[i] <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                d2_v_reg[i] <= 1'b0;
            k_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            sq_v_reg[0] <= g_v_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                sq_v_reg[i] <= sq_v_reg[i-1];
            h_v_reg <= sq_v_reg[SQRT_STAGES-1];
            d1_v_reg[0] <= h_v_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                d1_v_reg[i] <= d1_v_reg[i-1];
            i_v_reg <= d1_v_reg[DIV_STAGES-1];
            j_v_reg <= i_v_reg;
            d2_v_reg[0] <= j_v_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                d2_v_reg[i] <= d2_v_reg[i-1];
            k_v_reg <= d2_v_reg[DIV_STAGES-1];
            l_v_reg <= k_v_reg;
        end
    end

    assign out_valid = l_v_reg;
    assign cost = cost_reg;

endmodule

// ----- src/tec_checker.sv -----
module tec_checker
    import tec_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [ADDR_W-1:0]     paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COST_W-1:0]     cost
);

    // a waiting cost word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cost))
        else $error("cost word changed while stalled");

    // the pipe only blocks input when its last word is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // saturation ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cost <= COST_MAX)
        else $error("cost above saturation limit");

    // a written time_sensitive register reads back on the following cycle at the same address
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == '0 ##1 paddr == '0 && !(psel && penable && pwrite)
        |-> prdata == {31'b0, $past(pwdata[0])})
        else $error("time_sensitive readback mismatch");

endmodule

bind transit_edge_cost tec_checker u_tec_checker (.*);
